FILE: hw/rtl/linear_projection_nearest_centroid_assert.svh
// Assertion macros used by the sequencer (lpnc_seq) of the nearest-centroid classifier.
`ifndef LINEAR_PROJECTION_NEAREST_CENTROID_ASSERT_SVH
`define LINEAR_PROJECTION_NEAREST_CENTROID_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define LPNC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off during reset.
`define LPNC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/lpnc_pkg.sv
// Shared constants and types of the nearest-centroid classifier.
package lpnc_pkg;

   localparam int NUM_FEATURES_DEF = 5;
   localparam int NUM_CLASSES_DEF  = 7;

   localparam int IN_FIELDS = 5;    // feature ports on the request channel
   localparam int ACTION_W  = 2;
   localparam int IDX_W     = 3;
   localparam int LOAD_W    = 24;
   localparam int FEAT_W    = 16;   // Q4.12
   localparam int WEIGHT_W  = 16;   // Q4.12
   localparam int CENT_W    = 24;   // Q12.12
   localparam int Y_W       = 24;   // projected element, Q12.12
   localparam int CLASS_W   = 3;
   localparam int DIST_W    = 51;
   localparam int FRAC_BITS = 12;
   localparam int MUL_W     = 26;   // shared multiplier operand width
   localparam int PROD_W    = 2 * MUL_W;

   typedef enum logic [ACTION_W-1:0] {
      ACT_WR_WEIGHT   = 2'd0,
      ACT_WR_CENTROID = 2'd1,
      ACT_CLASSIFY    = 2'd2
   } action_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_PROJ,
      ST_GAP,
      ST_DIST,
      ST_DRAIN_B,
      ST_DRAIN_C,
      ST_FINISH
   } state_type;

   // Tag that travels with each table read down the datapath.
   typedef struct packed {
      logic valid;
      logic dist_step;   // 1: distance step, 0: projection step
      logic first;       // first term of a sum
      logic last;        // last term of a sum
   } tag_type;

endpackage

FILE: hw/rtl/lpnc_tables.sv
// Weight and centroid memories with registered reads.
module lpnc_tables #(
   parameter int NUM_FEATURES = lpnc_pkg::NUM_FEATURES_DEF,
   parameter int NUM_CLASSES  = lpnc_pkg::NUM_CLASSES_DEF,
   localparam int W_D    = NUM_FEATURES * NUM_FEATURES,
   localparam int C_D    = NUM_CLASSES * NUM_FEATURES,
   localparam int MAX_D  = (W_D > C_D) ? W_D : C_D,
   localparam int ADDR_W = $clog2(MAX_D)
) (
   input  logic                                  clock,
   input  logic                                  clr_en,
   input  logic [ADDR_W-1:0]                     addr,
   input  logic                                  w_re,
   input  logic                                  c_re,
   input  logic                                  wr_w_en,
   input  logic                                  wr_c_en,
   input  logic [ADDR_W-1:0]                     wr_addr,
   input  logic signed [lpnc_pkg::WEIGHT_W-1:0]  wr_w_data,
   input  logic signed [lpnc_pkg::CENT_W-1:0]    wr_c_data,
   output logic signed [lpnc_pkg::WEIGHT_W-1:0]  w_rdata,
   output logic signed [lpnc_pkg::CENT_W-1:0]    c_rdata
);

   localparam int W_AW = (W_D > 1) ? $clog2(W_D) : 1;
   localparam int C_AW = $clog2(C_D);

   logic signed [lpnc_pkg::WEIGHT_W-1:0] w_mem [W_D];
   logic signed [lpnc_pkg::CENT_W-1:0]   c_mem [C_D];

   logic signed [lpnc_pkg::WEIGHT_W-1:0] w_rdata_ff;
   logic signed [lpnc_pkg::CENT_W-1:0]   c_rdata_ff;

   logic                                 w_we;
   logic                                 c_we;
   logic [ADDR_W-1:0]                    waddr;
   logic signed [lpnc_pkg::WEIGHT_W-1:0] w_wdata;
   logic signed [lpnc_pkg::CENT_W-1:0]   c_wdata;

   // clear sweep shares the write port with loads
   always_comb begin
      w_we    = wr_w_en || (clr_en && ({1'b0, addr} < (ADDR_W + 1)'(W_D)));
      c_we    = wr_c_en || (clr_en && ({1'b0, addr} < (ADDR_W + 1)'(C_D)));
      waddr   = clr_en ? addr : wr_addr;
      w_wdata = clr_en ? '0 : wr_w_data;
      c_wdata = clr_en ? '0 : wr_c_data;
   end

   always_ff @(posedge clock) begin
      if (w_we) begin
         w_mem[waddr[W_AW-1:0]] <= w_wdata;
      end
      if (w_re) begin
         w_rdata_ff <= w_mem[addr[W_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem[waddr[C_AW-1:0]] <= c_wdata;
      end
      if (c_re) begin
         c_rdata_ff <= c_mem[addr[C_AW-1:0]];
      end
   end

   assign w_rdata = w_rdata_ff;
   assign c_rdata = c_rdata_ff;

endmodule

FILE: hw/rtl/lpnc_seq.sv
// Sequencer: clear sweep, projection and distance address walks, result hand-off.
`include "linear_projection_nearest_centroid_assert.svh"

module lpnc_seq #(
   parameter int NUM_FEATURES = lpnc_pkg::NUM_FEATURES_DEF,
   parameter int NUM_CLASSES  = lpnc_pkg::NUM_CLASSES_DEF,
   localparam int FI_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1,
   localparam int CI_W   = $clog2(NUM_CLASSES),
   localparam int W_D    = NUM_FEATURES * NUM_FEATURES,
   localparam int C_D    = NUM_CLASSES * NUM_FEATURES,
   localparam int MAX_D  = (W_D > C_D) ? W_D : C_D,
   localparam int ADDR_W = $clog2(MAX_D)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic                  out_free,
   output logic                  idle,
   output logic                  load_rsp,
   output logic                  clr_en,
   output logic                  w_re,
   output logic                  c_re,
   output logic [ADDR_W-1:0]     addr,
   output lpnc_pkg::tag_type     tagb,
   output logic [FI_W-1:0]       featb,
   output logic [FI_W-1:0]       pidxb,
   output logic [CI_W-1:0]       clsb
);

   lpnc_pkg::state_type state_ff, state_in;
   logic [ADDR_W-1:0]   addr_ff, addr_in;
   logic [FI_W-1:0]     inner_ff, inner_in;   // j in projection, i in distance
   logic [FI_W-1:0]     pout_ff, pout_in;     // projected element being summed
   logic [CI_W-1:0]     c_ff, c_in;           // class being measured
   lpnc_pkg::tag_type   taga;
   lpnc_pkg::tag_type   tagb_ff;
   logic [FI_W-1:0]     featb_ff;
   logic [FI_W-1:0]     pidxb_ff;
   logic [CI_W-1:0]     clsb_ff;

   logic inner_last;
   logic pout_last;
   logic c_last;
   logic clr_last;

   assign inner_last = (inner_ff == FI_W'(NUM_FEATURES - 1));
   assign pout_last  = (pout_ff == FI_W'(NUM_FEATURES - 1));
   assign c_last     = (c_ff == CI_W'(NUM_CLASSES - 1));
   assign clr_last   = (addr_ff == ADDR_W'(MAX_D - 1));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lpnc_pkg::ST_CLEAR:   if (clr_last) state_in = lpnc_pkg::ST_IDLE;
         lpnc_pkg::ST_IDLE:    if (start) state_in = lpnc_pkg::ST_PROJ;
         lpnc_pkg::ST_PROJ:    if (inner_last && pout_last) state_in = lpnc_pkg::ST_GAP;
         lpnc_pkg::ST_GAP:     state_in = lpnc_pkg::ST_DIST;
         lpnc_pkg::ST_DIST:    if (inner_last && c_last) state_in = lpnc_pkg::ST_DRAIN_B;
         lpnc_pkg::ST_DRAIN_B: state_in = lpnc_pkg::ST_DRAIN_C;
         lpnc_pkg::ST_DRAIN_C: state_in = lpnc_pkg::ST_FINISH;
         lpnc_pkg::ST_FINISH:  if (out_free) state_in = lpnc_pkg::ST_IDLE;
         default:              state_in = lpnc_pkg::ST_IDLE;
      endcase
   end

   // address and loop counters
   always_comb begin
      addr_in  = addr_ff;
      inner_in = inner_ff;
      pout_in  = pout_ff;
      c_in     = c_ff;
      case (state_ff)
         lpnc_pkg::ST_CLEAR: begin
            addr_in = clr_last ? '0 : addr_ff + 1'b1;
         end
         lpnc_pkg::ST_IDLE: begin
            addr_in  = '0;
            inner_in = '0;
            pout_in  = '0;
            c_in     = '0;
         end
         lpnc_pkg::ST_PROJ: begin
            // weight entry [j][i] sits at j*NF + i
            if (inner_last) begin
               inner_in = '0;
               if (pout_last) begin
                  addr_in = '0;
               end else begin
                  pout_in = pout_ff + 1'b1;
                  addr_in = ADDR_W'(pout_ff) + 1'b1;
               end
            end else begin
               inner_in = inner_ff + 1'b1;
               addr_in  = addr_ff + ADDR_W'(NUM_FEATURES);
            end
         end
         lpnc_pkg::ST_DIST: begin
            addr_in = addr_ff + 1'b1;
            if (inner_last) begin
               inner_in = '0;
               c_in     = c_ff + 1'b1;
            end else begin
               inner_in = inner_ff + 1'b1;
            end
         end
         default: begin
            addr_in = addr_ff;
         end
      endcase
   end

   // outputs
   always_comb begin
      idle           = (state_ff == lpnc_pkg::ST_IDLE);
      clr_en         = (state_ff == lpnc_pkg::ST_CLEAR);
      w_re           = (state_ff == lpnc_pkg::ST_PROJ);
      c_re           = (state_ff == lpnc_pkg::ST_DIST);
      load_rsp       = (state_ff == lpnc_pkg::ST_FINISH) && out_free;
      taga.valid     = w_re || c_re;
      taga.dist_step = c_re;
      taga.first     = (inner_ff == '0);
      taga.last      = inner_last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lpnc_pkg::ST_CLEAR;
         addr_ff  <= '0;
         inner_ff <= '0;
         pout_ff  <= '0;
         c_ff     <= '0;
         tagb_ff  <= '0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         inner_ff <= inner_in;
         pout_ff  <= pout_in;
         c_ff     <= c_in;
         tagb_ff  <= taga;
      end
   end

   // indices ride along with the read, aligned to the memory output
   always_ff @(posedge clock) begin
      featb_ff <= inner_ff;
      pidxb_ff <= pout_ff;
      clsb_ff  <= c_ff;
   end

   assign addr  = addr_ff;
   assign tagb  = tagb_ff;
   assign featb = featb_ff;
   assign pidxb = pidxb_ff;
   assign clsb  = clsb_ff;

   `LPNC_ASSERT_SAME(a_proj_addr, state_ff == lpnc_pkg::ST_PROJ, addr_ff == ADDR_W'(int'(inner_ff) * NUM_FEATURES + int'(pout_ff)), "projection address out of step with counters")
   `LPNC_ASSERT_SAME(a_dist_addr, state_ff == lpnc_pkg::ST_DIST, addr_ff == ADDR_W'(int'(c_ff) * NUM_FEATURES + int'(inner_ff)), "distance address out of step with counters")
   `LPNC_ASSERT_NEXT(a_tag_issue, (state_ff == lpnc_pkg::ST_PROJ) || (state_ff == lpnc_pkg::ST_DIST), tagb_ff.valid, "table read lost its tag")
   `LPNC_ASSERT_NEXT(a_tag_quiet, (state_ff != lpnc_pkg::ST_PROJ) && (state_ff != lpnc_pkg::ST_DIST), !tagb_ff.valid, "tag without a table read")

endmodule

FILE: hw/rtl/lpnc_dp.sv
// Datapath: shared multiplier, accumulator, projection registers, best-class tracking.
module lpnc_dp #(
   parameter int NUM_FEATURES = lpnc_pkg::NUM_FEATURES_DEF,
   parameter int NUM_CLASSES  = lpnc_pkg::NUM_CLASSES_DEF,
   localparam int FI_W = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1,
   localparam int CI_W = $clog2(NUM_CLASSES)
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  x_load,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]    feat [lpnc_pkg::IN_FIELDS],
   input  logic signed [lpnc_pkg::WEIGHT_W-1:0]  w_rdata,
   input  logic signed [lpnc_pkg::CENT_W-1:0]    c_rdata,
   input  lpnc_pkg::tag_type                     tagb,
   input  logic [FI_W-1:0]                       featb,
   input  logic [FI_W-1:0]                       pidxb,
   input  logic [CI_W-1:0]                       clsb,
   output logic [CI_W-1:0]                       best_cls,
   output logic [lpnc_pkg::DIST_W-1:0]           best_dist
);

   localparam int ACC_W = lpnc_pkg::PROD_W + FI_W;
   localparam logic signed [ACC_W-1:0] Y_HI = ACC_W'(2 ** (lpnc_pkg::Y_W - 1) - 1);
   localparam logic signed [ACC_W-1:0] Y_LO = ACC_W'(-(2 ** (lpnc_pkg::Y_W - 1)));
   localparam logic [ACC_W-1:0] D_HI = ACC_W'({lpnc_pkg::DIST_W{1'b1}});

   logic signed [lpnc_pkg::FEAT_W-1:0]  x_src [NUM_FEATURES];
   logic signed [lpnc_pkg::FEAT_W-1:0]  x_ff  [NUM_FEATURES];
   logic signed [lpnc_pkg::Y_W-1:0]     y_ff  [NUM_FEATURES];

   logic signed [lpnc_pkg::MUL_W-1:0]   diff;
   logic signed [lpnc_pkg::MUL_W-1:0]   op_a;
   logic signed [lpnc_pkg::MUL_W-1:0]   op_b;
   logic signed [lpnc_pkg::PROD_W-1:0]  prod_in;
   logic signed [lpnc_pkg::PROD_W-1:0]  prod_ff;

   lpnc_pkg::tag_type                   tagc_ff;
   logic [FI_W-1:0]                     pidxc_ff;
   logic [CI_W-1:0]                     clsc_ff;

   logic signed [ACC_W-1:0]             acc_ff;
   logic signed [ACC_W-1:0]             acc_base;
   logic signed [ACC_W-1:0]             sum;
   logic signed [ACC_W-1:0]             shifted;
   logic signed [lpnc_pkg::Y_W-1:0]     y_new;
   logic [lpnc_pkg::DIST_W-1:0]         dist_sat;
   logic                                better;

   logic [CI_W-1:0]                     best_cls_ff;
   logic [lpnc_pkg::DIST_W-1:0]         best_dist_ff;

   // features past the last port read as zero
   for (genvar k = 0; k < NUM_FEATURES; k++) begin : g_xsrc
      if (k < lpnc_pkg::IN_FIELDS) begin : g_port
         assign x_src[k] = feat[k];
      end else begin : g_zero
         assign x_src[k] = '0;
      end
   end

   // stage B: operand select and multiply
   always_comb begin
      diff = lpnc_pkg::MUL_W'(c_rdata) - lpnc_pkg::MUL_W'(y_ff[featb]);
      if (tagb.dist_step) begin
         op_a = diff;
         op_b = diff;
      end else begin
         op_a = lpnc_pkg::MUL_W'(x_ff[featb]);
         op_b = lpnc_pkg::MUL_W'(w_rdata);
      end
      prod_in = op_a * op_b;
   end

   // stage C: accumulate, then clamp or saturate at the end of a sum
   always_comb begin
      acc_base = tagc_ff.first ? '0 : acc_ff;
      sum      = acc_base + ACC_W'(prod_ff);
      shifted  = sum >>> lpnc_pkg::FRAC_BITS;   // floor divide by 4096
      if (shifted > Y_HI) begin
         y_new = Y_HI[lpnc_pkg::Y_W-1:0];
      end else if (shifted < Y_LO) begin
         y_new = Y_LO[lpnc_pkg::Y_W-1:0];
      end else begin
         y_new = shifted[lpnc_pkg::Y_W-1:0];
      end
      dist_sat = ($unsigned(sum) > D_HI) ? {lpnc_pkg::DIST_W{1'b1}} : sum[lpnc_pkg::DIST_W-1:0];
      better   = (clsc_ff == '0) || (dist_sat < best_dist_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tagc_ff <= '0;
      end else begin
         tagc_ff <= tagb;
      end
   end

   always_ff @(posedge clock) begin
      if (x_load) begin
         for (int k = 0; k < NUM_FEATURES; k++) begin
            x_ff[k] <= x_src[k];
         end
      end
      prod_ff  <= prod_in;
      pidxc_ff <= pidxb;
      clsc_ff  <= clsb;
      if (tagc_ff.valid) begin
         acc_ff <= sum;
         if (tagc_ff.last) begin
            if (!tagc_ff.dist_step) begin
               y_ff[pidxc_ff] <= y_new;
            end else if (better) begin
               best_dist_ff <= dist_sat;
               best_cls_ff  <= clsc_ff;
            end
         end
      end
   end

   assign best_cls  = best_cls_ff;
   assign best_dist = best_dist_ff;

endmodule

FILE: hw/rtl/linear_projection_nearest_centroid.sv
// Top level of the nearest-centroid classifier with linear projection front end.
//
// Each request word either loads one table entry or classifies a feature vector.
// Weight writes (row = input feature, col = projected element) saturate the value to
// signed 16-bit Q4.12; centroid writes (row = class, col = element) store 24-bit Q12.12
// as given; writes outside the table, and action code 3, are dropped without a response.
// Writes give no response and leave the sequencer idle. A classify word runs through one
// shared 26x26 multiplier fed by the two tables, one table entry per cycle: NUM_FEATURES^2
// projection products, a bubble, NUM_CLASSES*NUM_FEATURES squared differences, pipeline
// drain through stages B and C, and a hand-off that waits until the response register is
// free; the next request is taken the cycle after the hand-off. The multiplier and the
// single read port of each table keep these steps serial. The response word carries the
// lowest-index nearest class and its squared distance (Q24, saturated to 51 bits); it
// sits in an output register, so requests keep flowing while it waits. After reset both
// tables are swept to zero, one entry per cycle over addresses 0 to max(NF*NF, NC*NF)-1,
// with req_ready low during the sweep.
module linear_projection_nearest_centroid #(
   parameter int NUM_FEATURES = lpnc_pkg::NUM_FEATURES_DEF,
   parameter int NUM_CLASSES  = lpnc_pkg::NUM_CLASSES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [lpnc_pkg::ACTION_W-1:0]        req_action,
   input  logic [lpnc_pkg::IDX_W-1:0]           req_row_index,
   input  logic [lpnc_pkg::IDX_W-1:0]           req_col_index,
   input  logic signed [lpnc_pkg::LOAD_W-1:0]   req_load_value,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]   req_feature_0,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]   req_feature_1,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]   req_feature_2,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]   req_feature_3,
   input  logic signed [lpnc_pkg::FEAT_W-1:0]   req_feature_4,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [lpnc_pkg::CLASS_W-1:0]         rsp_class_index,
   output logic [lpnc_pkg::DIST_W-1:0]          rsp_best_distance
);

   localparam int FI_W   = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;
   localparam int CI_W   = $clog2(NUM_CLASSES);
   localparam int W_D    = NUM_FEATURES * NUM_FEATURES;
   localparam int C_D    = NUM_CLASSES * NUM_FEATURES;
   localparam int MAX_D  = (W_D > C_D) ? W_D : C_D;
   localparam int ADDR_W = $clog2(MAX_D);
   localparam logic signed [lpnc_pkg::LOAD_W-1:0] W_HI = lpnc_pkg::LOAD_W'(32767);
   localparam logic signed [lpnc_pkg::LOAD_W-1:0] W_LO = lpnc_pkg::LOAD_W'(-32768);

   logic                                  accept;
   logic                                  start;
   logic                                  idle;
   logic                                  load_rsp;
   logic                                  out_free;
   logic                                  clr_en;
   logic                                  w_re;
   logic                                  c_re;
   logic [ADDR_W-1:0]                     addr;
   logic                                  wr_w_en;
   logic                                  wr_c_en;
   logic [ADDR_W-1:0]                     wr_addr;
   logic signed [lpnc_pkg::WEIGHT_W-1:0]  wr_w_data;
   logic signed [lpnc_pkg::WEIGHT_W-1:0]  w_rdata;
   logic signed [lpnc_pkg::CENT_W-1:0]    c_rdata;
   lpnc_pkg::tag_type                     tagb;
   logic [FI_W-1:0]                       featb;
   logic [FI_W-1:0]                       pidxb;
   logic [CI_W-1:0]                       clsb;
   logic [CI_W-1:0]                       best_cls;
   logic [lpnc_pkg::DIST_W-1:0]           best_dist;
   logic signed [lpnc_pkg::FEAT_W-1:0]    feat [lpnc_pkg::IN_FIELDS];

   logic                                  rsp_valid_ff, rsp_valid_in;
   logic [lpnc_pkg::CLASS_W-1:0]          rsp_class_index_ff;
   logic [lpnc_pkg::DIST_W-1:0]           rsp_best_distance_ff;

   // request decode
   assign req_ready = idle;
   assign accept    = req_valid && req_ready;
   assign start     = accept && (req_action == lpnc_pkg::ACT_CLASSIFY);

   always_comb begin
      wr_w_en = accept && (req_action == lpnc_pkg::ACT_WR_WEIGHT)
                && (int'(req_row_index) < NUM_FEATURES)
                && (int'(req_col_index) < NUM_FEATURES);
      wr_c_en = accept && (req_action == lpnc_pkg::ACT_WR_CENTROID)
                && (int'(req_row_index) < NUM_CLASSES)
                && (int'(req_col_index) < NUM_FEATURES);
      // both tables are row-major with NUM_FEATURES columns
      wr_addr = ADDR_W'(int'(req_row_index) * NUM_FEATURES + int'(req_col_index));
      if (req_load_value > W_HI) begin
         wr_w_data = W_HI[lpnc_pkg::WEIGHT_W-1:0];
      end else if (req_load_value < W_LO) begin
         wr_w_data = W_LO[lpnc_pkg::WEIGHT_W-1:0];
      end else begin
         wr_w_data = req_load_value[lpnc_pkg::WEIGHT_W-1:0];
      end
   end

   assign feat[0] = req_feature_0;
   assign feat[1] = req_feature_1;
   assign feat[2] = req_feature_2;
   assign feat[3] = req_feature_3;
   assign feat[4] = req_feature_4;

   lpnc_tables #(
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_tables (
      .clock     (clock),
      .clr_en    (clr_en),
      .addr      (addr),
      .w_re      (w_re),
      .c_re      (c_re),
      .wr_w_en   (wr_w_en),
      .wr_c_en   (wr_c_en),
      .wr_addr   (wr_addr),
      .wr_w_data (wr_w_data),
      .wr_c_data (req_load_value),
      .w_rdata   (w_rdata),
      .c_rdata   (c_rdata)
   );

   lpnc_seq #(
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .out_free (out_free),
      .idle     (idle),
      .load_rsp (load_rsp),
      .clr_en   (clr_en),
      .w_re     (w_re),
      .c_re     (c_re),
      .addr     (addr),
      .tagb     (tagb),
      .featb    (featb),
      .pidxb    (pidxb),
      .clsb     (clsb)
   );

   lpnc_dp #(
      .NUM_FEATURES (NUM_FEATURES),
      .NUM_CLASSES  (NUM_CLASSES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .x_load    (start),
      .feat      (feat),
      .w_rdata   (w_rdata),
      .c_rdata   (c_rdata),
      .tagb      (tagb),
      .featb     (featb),
      .pidxb     (pidxb),
      .clsb      (clsb),
      .best_cls  (best_cls),
      .best_dist (best_dist)
   );

   // response register: a finished result waits here
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_class_index_ff   <= lpnc_pkg::CLASS_W'(best_cls);
         rsp_best_distance_ff <= best_dist;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_class_index   = rsp_class_index_ff;
   assign rsp_best_distance = rsp_best_distance_ff;

endmodule
